// File: src/i2wt_pkg.sv
package i2wt_pkg;

    // Field and bus widths
    localparam int ValueW   = 31;
    localparam int DataInW  = 32;
    localparam int WordW    = 5;
    localparam int DataOutW = 8;

    // Binary to BCD conversion: ten decimal digits, two bits a cycle
    localparam int NumDigits     = 10;
    localparam int BcdW          = 4 * NumDigits;
    localparam int BinW          = 32;
    localparam int StepsPerCycle = 2;
    localparam int ConvCycles    = BinW / StepsPerCycle;
    localparam int CntW          = $clog2(ConvCycles);

    // Token slots: four groups of five slots, then one slot for Zero
    localparam int NumGroups     = 4;
    localparam int SlotsPerGroup = 5;
    localparam int ZeroPos       = NumGroups * SlotsPerGroup;
    localparam int NumPos        = ZeroPos + 1;
    localparam int PosW          = $clog2(NumPos);

    typedef logic [WordW-1:0] word_t;
    typedef logic [3:0]       digit_t;

    // Word token codes
    localparam word_t TOK_ZERO      = 5'd0;
    localparam word_t TOK_TEN       = 5'd10;
    localparam word_t TOK_TENS_BASE = 5'd18;
    localparam word_t TOK_HUNDRED   = 5'd28;
    localparam word_t TOK_THOUSAND  = 5'd29;
    localparam word_t TOK_MILLION   = 5'd30;
    localparam word_t TOK_BILLION   = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_BUILD,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic build;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_tok;
    } status_t;

    // One shift-and-add-3 step over all digits
    function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] bcd,
                                               input logic bit_in);
        logic [BcdW-1:0] adj;
        adj = bcd;
        for (int i = 0; i < NumDigits; i++) begin
            if (adj[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BcdW-2:0], bit_in};
    endfunction

    // Index of the lowest set bit
    function automatic logic [PosW-1:0] lowest_pos(input logic [NumPos-1:0] m);
        logic [PosW-1:0] p;
        p = '0;
        for (int i = NumPos - 1; i >= 0; i--) begin
            if (m[i]) begin
                p = PosW'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: src/i2wt_ctrl.sv
module i2wt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output i2wt_pkg::cmd_t    cmd,
    input  i2wt_pkg::status_t status
);
    import i2wt_pkg::*;

    state_t            state_reg, state_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sequence one number: accept, convert, build slot mask, emit tokens
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + CntW'(1);
                if (cnt_reg == CntW'(ConvCycles - 1)) begin
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD: begin
                cmd.build  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_tok) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/i2wt_datapath.sv
module i2wt_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  i2wt_pkg::cmd_t                    cmd,
    output i2wt_pkg::status_t                 status,
    input  logic [i2wt_pkg::DataInW-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2wt_pkg::DataOutW-1:0]     m_tdata,
    output logic                              m_tlast
);
    import i2wt_pkg::*;

    logic [BinW-1:0]   bin_reg;
    logic [BcdW-1:0]   bcd_reg;
    logic [NumPos-1:0] mask_reg;
    logic              m_tvalid_reg;
    word_t             word_reg;
    logic              last_reg;

    logic [BcdW-1:0]   bcd_step1, bcd_step2;
    digit_t            grp_h [NumGroups];
    digit_t            grp_t [NumGroups];
    digit_t            grp_o [NumGroups];
    word_t             grp_scale [NumGroups];
    logic [NumPos-1:0] slot_valid;
    word_t             tok_vec [2**PosW];
    logic [PosW-1:0]   pos;
    logic [NumPos-1:0] mask_rest;

    // Two conversion steps a cycle, top bits of the binary word first
    assign bcd_step1 = dabble(bcd_reg, bin_reg[BinW-1]);
    assign bcd_step2 = dabble(bcd_step1, bin_reg[BinW-2]);

    // Split digits into groups, billion group first
    always_comb begin
        grp_h[0] = '0;
        grp_t[0] = '0;
        grp_o[0] = bcd_reg[39:36];
        grp_h[1] = bcd_reg[35:32];
        grp_t[1] = bcd_reg[31:28];
        grp_o[1] = bcd_reg[27:24];
        grp_h[2] = bcd_reg[23:20];
        grp_t[2] = bcd_reg[19:16];
        grp_o[2] = bcd_reg[15:12];
        grp_h[3] = bcd_reg[11:8];
        grp_t[3] = bcd_reg[7:4];
        grp_o[3] = bcd_reg[3:0];
        grp_scale[0] = TOK_BILLION;
        grp_scale[1] = TOK_MILLION;
        grp_scale[2] = TOK_THOUSAND;
        grp_scale[3] = TOK_ZERO;
    end

    // Work out which slots speak and what each one says
    always_comb begin
        for (int p = 0; p < 2**PosW; p++) begin
            tok_vec[p] = TOK_ZERO;
        end
        slot_valid = '0;
        for (int g = 0; g < NumGroups; g++) begin
            slot_valid[g*SlotsPerGroup + 0] = (grp_h[g] != '0);
            slot_valid[g*SlotsPerGroup + 1] = (grp_h[g] != '0);
            slot_valid[g*SlotsPerGroup + 2] = (grp_t[g] != '0) || (grp_o[g] != '0);
            slot_valid[g*SlotsPerGroup + 3] = (grp_t[g] >= 4'd2) && (grp_o[g] != '0);
            slot_valid[g*SlotsPerGroup + 4] = (g != NumGroups - 1) &&
                ((grp_h[g] != '0) || (grp_t[g] != '0) || (grp_o[g] != '0));

            tok_vec[g*SlotsPerGroup + 0] = {1'b0, grp_h[g]};
            tok_vec[g*SlotsPerGroup + 1] = TOK_HUNDRED;
            if (grp_t[g] >= 4'd2) begin
                tok_vec[g*SlotsPerGroup + 2] = TOK_TENS_BASE + {1'b0, grp_t[g]};
            end else if (grp_t[g] == 4'd1) begin
                tok_vec[g*SlotsPerGroup + 2] = TOK_TEN + {1'b0, grp_o[g]};
            end else begin
                tok_vec[g*SlotsPerGroup + 2] = {1'b0, grp_o[g]};
            end
            tok_vec[g*SlotsPerGroup + 3] = {1'b0, grp_o[g]};
            tok_vec[g*SlotsPerGroup + 4] = grp_scale[g];
        end
        slot_valid[ZeroPos] = (bcd_reg == '0);
        tok_vec[ZeroPos]    = TOK_ZERO;
    end

    // Next token is the lowest pending slot
    assign pos       = lowest_pos(mask_reg);
    assign mask_rest = mask_reg & (mask_reg - NumPos'(1));

    assign status.last_tok = (mask_rest == '0);
    assign status.out_free = !m_tvalid_reg || m_tready;

    // Conversion and slot mask registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg <= {{(BinW - ValueW){1'b0}}, s_tdata[ValueW-1:0]};
            bcd_reg <= '0;
        end else if (cmd.shift) begin
            bin_reg <= {bin_reg[BinW-StepsPerCycle-1:0], {StepsPerCycle{1'b0}}};
            bcd_reg <= bcd_step2;
        end
        if (cmd.build) begin
            mask_reg <= slot_valid;
        end else if (cmd.emit) begin
            mask_reg <= mask_rest;
        end
    end

    // Output register: load on emit, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            word_reg <= tok_vec[pos];
            last_reg <= (mask_rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(DataOutW - WordW){1'b0}}, word_reg};
    assign m_tlast  = last_reg;

endmodule

// File: src/integer_to_word_tokens.sv
// Spells a non-negative integer as a run of English number word tokens.
// Input channel s_*: one item per number, value in s_tdata[30:0].
// Output channel m_*: one item per word token, code in m_tdata[4:0],
// m_tlast high on the final token of the number.
// Each number is first converted to ten BCD digits by a shift-and-add-3
// unit that takes two bits a cycle, then a slot mask of the tokens to
// speak is built, then tokens leave one per cycle while the receiver
// keeps up. A number spells as one to sixteen tokens.
// The next number is accepted as soon as the final token has been loaded
// into the output register, even if the receiver has not yet taken it.
// If the receiver stalls, the current token holds in the output register
// and emission pauses. Reset (aresetn low, synchronous) returns the
// controller to idle and clears the output valid.
module integer_to_word_tokens (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [i2wt_pkg::DataInW-1:0]  s_tdata,   // [30:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2wt_pkg::DataOutW-1:0] m_tdata,   // [4:0] word
    output logic                          m_tlast
);
    import i2wt_pkg::*;

    cmd_t    cmd;
    status_t status;

    i2wt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    i2wt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: src/i2wt_checker.sv
module i2wt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [i2wt_pkg::DataOutW-1:0] m_tdata,
    input logic                          m_tlast
);
    import i2wt_pkg::*;

    // Hold a stalled token
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token changed or dropped");

    // Busy for the conversion once a number is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again during conversion");

    // A pending non-final token means the number is still in progress
    a_no_accept_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while a run is unfinished");

    // Padding bits above the word stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DataOutW-1:WordW] == '0))
        else $error("padding bits of m_tdata set");

endmodule

bind integer_to_word_tokens i2wt_checker u_i2wt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: dv/integer_to_word_tokens_tb.sv
`timescale 1ns / 100ps

module integer_to_word_tokens_tb;
    import i2wt_pkg::*;

    typedef struct packed {
        word_t word;
        logic  last;
    } word_token_t;

    localparam int ClkHalf     = 2;
    localparam int RandomItems = 160;
    localparam int CalmItems   = 30;
    localparam int HoldOffLen  = 400;
    localparam int DrainCycles = 60;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DataInW-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DataOutW-1:0] m_tdata;
    logic                m_tlast;

    logic [DataInW-1:0] pending_values[$];
    word_token_t        expected_tokens[$];
    int                 numbers_taken   = 0;
    int                 number_total    = 0;
    int                 mismatch_count  = 0;
    int                 send_gap        = 0;
    int                 recv_gap        = 0;
    logic               number_taken    = 1'b0;
    logic               hold_off        = 1'b0;

    integer_to_word_tokens uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [30:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [4:0] word
        .m_tlast  (m_tlast)
    );

    always #ClkHalf aclk = ~aclk;

    // Spell one number as word tokens and queue them, last flag on the final one
    function automatic void spell_number(input logic [DataInW-1:0] raw);
        int unsigned v;
        int unsigned grp;
        int unsigned hund;
        int unsigned rest;
        int unsigned divisor[4];
        word_t       scale_word[4];
        word_t       words[$];
        word_token_t tok;
        divisor    = '{1000000000, 1000000, 1000, 1};
        scale_word = '{TOK_BILLION, TOK_MILLION, TOK_THOUSAND, TOK_ZERO};
        v = int'(raw[ValueW-1:0]);
        if (v == 0) begin
            words.push_back(TOK_ZERO);
        end
        for (int i = 0; i < NumGroups; i++) begin
            grp  = (v / divisor[i]) % 1000;
            hund = grp / 100;
            rest = grp % 100;
            if (grp != 0) begin
                if (hund != 0) begin
                    words.push_back(word_t'(hund));
                    words.push_back(TOK_HUNDRED);
                end
                if (rest >= 20) begin
                    words.push_back(TOK_TENS_BASE + word_t'(rest / 10));
                    if (rest % 10 != 0) begin
                        words.push_back(word_t'(rest % 10));
                    end
                end else if (rest != 0) begin
                    words.push_back(word_t'(rest));
                end
                if (i < NumGroups - 1) begin
                    words.push_back(scale_word[i]);
                end
            end
        end
        foreach (words[k]) begin
            tok.word = words[k];
            tok.last = (k == words.size() - 1);
            expected_tokens.push_back(tok);
        end
    endfunction

    // Record accepted numbers and check every token that leaves the block
    always @(posedge aclk) begin
        word_token_t want;
        if (aresetn && s_tvalid && s_tready) begin
            spell_number(s_tdata);
            numbers_taken++;
            number_taken = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected token: tdata %0d tlast %0b", m_tdata, m_tlast);
                end
                mismatch_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (m_tdata !== DataOutW'(want.word) || m_tlast !== want.last) begin
                    if (mismatch_count < 10) begin
                        $display({"token mismatch: expected tdata %0d tlast %0b, ",
                                  "got tdata %0d tlast %0b"},
                                 want.word, want.last, m_tdata, m_tlast);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Offer numbers from the pending queue, with random idle bursts until the tail
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !number_taken) begin
            // hold the current item until it is taken
        end else begin
            number_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_values.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (numbers_taken < number_total - CalmItems
                         && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 8) - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_values.pop_front();
            end
        end
    end

    // Take tokens, stalling in random bursts and during the long hold-off
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (numbers_taken < number_total - CalmItems
                     && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 8) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Stall the receiver for a long stretch so the block backs up its input
    initial begin
        while (numbers_taken < 40) @(negedge aclk);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (HoldOffLen) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Build the stimulus, release reset, then wait for the block to drain
    initial begin
        logic [DataInW-1:0] val;
        longint unsigned    total;
        int unsigned        grp;
        // edges, every scale, teens, bare tens, the top bit ignored, sixteen tokens
        pending_values = '{32'd0, 32'h8000_0000, 32'd5, 32'd13, 32'd19, 32'd20, 32'd40,
                           32'd99, 32'd100, 32'd305, 32'd512, 32'd1000, 32'd1001,
                           32'd10000, 32'd1000000, 32'd1000000000, 32'd1777777777,
                           32'd2147483647, 32'hFFFF_FFFF, 32'd1002003004, 32'd50000070};
        for (int n = 0; n < RandomItems; n++) begin
            case ($urandom_range(0, 3))
                0: val = $urandom;
                1: val = $urandom_range(0, 999);
                default: begin
                    // compose from groups that favour zeros, teens and round tens
                    total = longint'($urandom_range(0, 2)) * 64'd1000000000;
                    for (int i = 0; i < 3; i++) begin
                        case ($urandom_range(0, 4))
                            0: grp = 0;
                            1: grp = $urandom_range(1, 19);
                            2: grp = 10 * $urandom_range(2, 9);
                            3: grp = 100 * $urandom_range(1, 9);
                            default: grp = $urandom_range(0, 999);
                        endcase
                        total = total * 0 + total + longint'(grp) * (i == 0 ? 1000000 :
                                                                     i == 1 ? 1000 : 1);
                    end
                    if (total > 64'd2147483647) begin
                        total = total - 64'd1000000000;
                    end
                    val = {($urandom_range(0, 7) == 0), total[30:0]};
                end
            endcase
            pending_values.push_back(val);
        end
        number_total = pending_values.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (numbers_taken < number_total) @(posedge aclk);
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
src/i2wt_pkg.sv
src/i2wt_ctrl.sv
src/i2wt_datapath.sv
src/integer_to_word_tokens.sv
src/i2wt_checker.sv
dv/integer_to_word_tokens_tb.sv
